// ----- rtl/pds_pkg.sv -----
`timescale 1ns / 1ps

package pds_pkg;

   localparam int CORDIC_ITERATIONS = 16;
   localparam int DIV_STAGES        = 36;
   localparam int PIPE_LATENCY      = 51 + CORDIC_ITERATIONS;

   localparam int CORDIC_W = 34;
   localparam int REM_W    = 60;
   localparam int DVS_W    = 32;
   localparam int QUO_W    = DIV_STAGES;

   localparam logic signed [31:0] INV_2PI_Q32     = 32'sd683565276;
   localparam logic signed [31:0] TWO_PI_Q28      = 32'sd1686629713;
   localparam logic signed [31:0] TWO_OVER_PI_Q30 = 32'sd683565276;
   localparam logic signed [31:0] GAIN_Q30        = 32'sd652032874;
   localparam logic signed [23:0] HALF_PI_Q16     = 24'sd102944;
   localparam logic signed [23:0] Q8_16_MAX       = 24'sd8388607;
   localparam logic signed [23:0] Q8_16_MIN       = -24'sd8388608;
   localparam logic signed [31:0] DEN_BIAS        = 32'sd335544320;
   localparam logic signed [45:0] SIN_GAIN        = 46'sd294;
   localparam logic signed [45:0] TERM_GAIN       = 46'sd3;
   localparam logic signed [31:0] COS_GAIN        = 32'sd3;
   localparam logic [45:0]        RECIP625        = 46'd57646075230343;
   localparam logic [31:0]        RECIP10         = 32'hCCCC_CCCD;
   localparam logic [28:0]        RECIP1000       = 29'd274877907;
   localparam logic [16:0]        ONE_Q16         = 17'd65536;

   localparam logic [29:0] ATAN_Q30 [0:30] = '{
      30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
      30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
      30'd1048575, 30'd524288, 30'd262144, 30'd131072, 30'd65536, 30'd32768,
      30'd16384, 30'd8192, 30'd4096, 30'd2048, 30'd1024, 30'd512, 30'd256,
      30'd128, 30'd64, 30'd32, 30'd16, 30'd8, 30'd4, 30'd2, 30'd1
   };

   typedef struct packed {
      logic signed [CORDIC_W-1:0] x;
      logic signed [CORDIC_W-1:0] y;
      logic signed [CORDIC_W-1:0] z;
   } cordic_type;

   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [DVS_W-1:0] dvs;
      logic [QUO_W-1:0] quo;
   } div_type;

endpackage

// ----- rtl/pds_cordic_stage.sv -----
`timescale 1ns / 1ps

module pds_cordic_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [4:0]           stage_idx,
   input  logic                 src_valid,
   input  pds_pkg::cordic_type  src_vec,
   output logic                 valid_ff,
   output pds_pkg::cordic_type  vec_ff
);
   import pds_pkg::*;

   logic signed [CORDIC_W-1:0] x_shift;
   logic signed [CORDIC_W-1:0] y_shift;
   logic signed [CORDIC_W-1:0] angle_step;
   logic                       valid_in;
   cordic_type                 vec_in;

   assign x_shift    = src_vec.x >>> stage_idx;
   assign y_shift    = src_vec.y >>> stage_idx;
   assign angle_step = CORDIC_W'(ATAN_Q30[stage_idx]);
   assign valid_in   = src_valid;

   always_comb begin
      if (!src_vec.z[CORDIC_W-1]) begin
         vec_in.x = src_vec.x - y_shift;
         vec_in.y = src_vec.y + x_shift;
         vec_in.z = src_vec.z - angle_step;
      end else begin
         vec_in.x = src_vec.x + y_shift;
         vec_in.y = src_vec.y - x_shift;
         vec_in.z = src_vec.z + angle_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      vec_ff <= vec_in;
   end

endmodule

// ----- rtl/pds_div_stage.sv -----
`timescale 1ns / 1ps

module pds_div_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic [5:0]        bit_idx,
   input  logic              src_valid,
   input  pds_pkg::div_type  src_div,
   output logic              valid_ff,
   output pds_pkg::div_type  div_ff
);
   import pds_pkg::*;

   localparam int CMP_W = DVS_W + QUO_W;

   logic [CMP_W-1:0] dvs_shift;
   logic [CMP_W-1:0] rem_wide;
   logic             fits;
   logic             valid_in;
   div_type          div_in;

   assign dvs_shift = CMP_W'(src_div.dvs) << bit_idx;
   assign rem_wide  = CMP_W'(src_div.rem);
   assign fits      = rem_wide >= dvs_shift;
   assign valid_in  = src_valid;

   always_comb begin
      div_in = src_div;
      if (fits) begin
         div_in.rem          = REM_W'(rem_wide - dvs_shift);
         div_in.quo[bit_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      div_ff <= div_in;
   end

endmodule

// ----- rtl/pendulum_dynamics_step_core.sv -----
`timescale 1ns / 1ps

// One Euler step of an inverted pendulum on a cart, fully pipelined. A new
// word may be started in every cycle, busy is always low, and each result
// appears on the rsp_ ports for one cycle with rsp_strobe high. The delay
// from start to result is set by one register per CORDIC iteration, one
// per quotient bit of the 36-stage restoring divider, and fifteen stages
// of angle reduction, multiply and reward arithmetic. The receiver cannot
// stall the block, so results must be captured when the strobe is high.
module pendulum_dynamics_step_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [23:0] req_angle,
   input  logic signed [23:0] req_rate,
   input  logic signed [22:0] req_action,
   input  logic signed [20:0] req_noise_sample,
   output logic               rsp_strobe,
   output logic signed [23:0] rsp_next_angle,
   output logic signed [23:0] rsp_next_rate,
   output logic [16:0]        rsp_reward,
   output logic               rsp_terminal
);
   import pds_pkg::*;

   localparam logic [1:0] QUAD_FIRST  = 2'd0;
   localparam logic [1:0] QUAD_SECOND = 2'd1;
   localparam logic [1:0] QUAD_THIRD  = 2'd2;
   localparam logic [1:0] QUAD_FOURTH = 2'd3;

   typedef struct packed {
      logic signed [23:0] th;
      logic signed [23:0] td;
      logic signed [23:0] u;
      logic [30:0]        t2;
      logic [1:0]         quad;
   } cside_type;

   typedef struct packed {
      logic signed [23:0] th;
      logic signed [23:0] td;
      logic               neg;
      logic [44:0]        ub;
   } dside_type;

   function automatic logic signed [23:0] sat24(input logic signed [26:0] v);
      logic signed [23:0] r;
      if (v > 27'(Q8_16_MAX)) begin
         r = Q8_16_MAX;
      end else if (v < 27'(Q8_16_MIN)) begin
         r = Q8_16_MIN;
      end else begin
         r = 24'(v);
      end
      return r;
   endfunction

   // Input register.
   logic               v1_ff;
   logic signed [23:0] th1_ff, td1_ff, u1_ff, u1_in;

   assign busy  = 1'b0;
   assign u1_in = 24'(req_action) + 24'(req_noise_sample);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= start && !busy;
      end
      th1_ff <= req_angle;
      td1_ff <= req_rate;
      u1_ff  <= u1_in;
   end

   // Angle to turns, rate squared.
   logic               v2_ff;
   logic signed [55:0] prod2_ff, prod2_in;
   logic signed [47:0] sq2_ff, sq2_in;
   logic signed [23:0] th2_ff, td2_ff, u2_ff;

   assign prod2_in = th1_ff * INV_2PI_Q32;
   assign sq2_in   = td1_ff * td1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      prod2_ff <= prod2_in;
      sq2_ff   <= sq2_in;
      th2_ff   <= th1_ff;
      td2_ff   <= td1_ff;
      u2_ff    <= u1_ff;
   end

   // Quadrant split and residual to radians.
   logic               v3_ff;
   logic [31:0]        phase3, phase_bias3, resid3;
   logic [1:0]         quad3;
   logic signed [63:0] turn3_ff, turn3_in;
   cside_type          side3_ff, side3_in;

   assign phase3      = prod2_ff[47:16];
   assign phase_bias3 = phase3 + 32'h2000_0000;
   assign quad3       = phase_bias3[31:30];
   assign resid3      = phase3 - {quad3, 30'd0};
   assign turn3_in    = $signed(resid3) * TWO_PI_Q28;

   always_comb begin
      side3_in.th   = th2_ff;
      side3_in.td   = td2_ff;
      side3_in.u    = u2_ff;
      side3_in.t2   = sq2_ff[46:16];
      side3_in.quad = quad3;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      turn3_ff <= turn3_in;
      side3_ff <= side3_in;
   end

   // CORDIC rotation, one iteration per stage.
   logic       cval [0:CORDIC_ITERATIONS];
   cordic_type cvec [0:CORDIC_ITERATIONS];
   cside_type  cside_ff [1:CORDIC_ITERATIONS];

   assign cval[0]   = v3_ff;
   assign cvec[0].x = CORDIC_W'(GAIN_Q30);
   assign cvec[0].y = '0;
   assign cvec[0].z = turn3_ff[63:30];

   for (genvar g = 0; g < CORDIC_ITERATIONS; g++) begin : g_cordic
      pds_cordic_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .stage_idx (5'(g)),
         .src_valid (cval[g]),
         .src_vec   (cvec[g]),
         .valid_ff  (cval[g+1]),
         .vec_ff    (cvec[g+1])
      );
   end

   always_ff @(posedge clock) begin
      cside_ff[1] <= side3_ff;
      for (int i = 1; i < CORDIC_ITERATIONS; i++) begin
         cside_ff[i+1] <= cside_ff[i];
      end
   end

   // Quadrant fix-up.
   logic                       v4_ff;
   logic signed [CORDIC_W-1:0] sn4_ff, cs4_ff, sn4_in, cs4_in;
   cside_type                  side4_ff;

   always_comb begin
      case (cside_ff[CORDIC_ITERATIONS].quad)
         QUAD_FIRST: begin
            cs4_in = cvec[CORDIC_ITERATIONS].x;
            sn4_in = cvec[CORDIC_ITERATIONS].y;
         end
         QUAD_SECOND: begin
            cs4_in = -cvec[CORDIC_ITERATIONS].y;
            sn4_in = cvec[CORDIC_ITERATIONS].x;
         end
         QUAD_THIRD: begin
            cs4_in = -cvec[CORDIC_ITERATIONS].x;
            sn4_in = -cvec[CORDIC_ITERATIONS].y;
         end
         QUAD_FOURTH: begin
            cs4_in = cvec[CORDIC_ITERATIONS].y;
            sn4_in = -cvec[CORDIC_ITERATIONS].x;
         end
         default: begin
            cs4_in = cvec[CORDIC_ITERATIONS].x;
            sn4_in = cvec[CORDIC_ITERATIONS].y;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= cval[CORDIC_ITERATIONS];
      end
      sn4_ff   <= sn4_in;
      cs4_ff   <= cs4_in;
      side4_ff <= cside_ff[CORDIC_ITERATIONS];
   end

   // Products sin*cos and cos^2.
   logic                       v5_ff;
   logic signed [67:0]         sc5_prod, cc5_prod;
   logic signed [CORDIC_W-1:0] sc5_ff, cc5_ff, sn5_ff, cs5_ff;
   cside_type                  side5_ff;

   assign sc5_prod = sn4_ff * cs4_ff;
   assign cc5_prod = cs4_ff * cs4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else begin
         v5_ff <= v4_ff;
      end
      sc5_ff   <= sc5_prod[63:30];
      cc5_ff   <= cc5_prod[63:30];
      sn5_ff   <= sn4_ff;
      cs5_ff   <= cs4_ff;
      side5_ff <= side4_ff;
   end

   // Numerator products and force squared.
   logic                       v6_ff;
   logic signed [65:0]         pa6_ff, pa6_in;
   logic signed [57:0]         pb6_ff, pb6_in;
   logic signed [47:0]         uu6_ff, uu6_in;
   logic signed [CORDIC_W-1:0] sn6_ff, cc6_ff;
   cside_type                  side6_ff;

   assign pa6_in = $signed({1'b0, side5_ff.t2}) * sc5_ff;
   assign pb6_in = cs5_ff * side5_ff.u;
   assign uu6_in = side5_ff.u * side5_ff.u;

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else begin
         v6_ff <= v5_ff;
      end
      pa6_ff   <= pa6_in;
      pb6_ff   <= pb6_in;
      uu6_ff   <= uu6_in;
      sn6_ff   <= sn5_ff;
      cc6_ff   <= cc5_ff;
      side6_ff <= side5_ff;
   end

   // Numerator and divisor.
   logic               v7_ff;
   logic signed [45:0] sn_t, pa_t, pb_t, num7_ff, num7_in;
   logic signed [31:0] den7_in;
   logic [DVS_W-1:0]   den7_ff;
   dside_type          side7_ff, side7_in;

   assign sn_t    = 46'(sn6_ff >>> 6);
   assign pa_t    = 46'(pa6_ff >>> 22);
   assign pb_t    = 46'(pb6_ff >>> 22);
   assign num7_in = sn_t * SIN_GAIN - pa_t * TERM_GAIN - pb_t * TERM_GAIN;
   assign den7_in = DEN_BIAS - 32'(cc6_ff >>> 6) * COS_GAIN;

   always_comb begin
      side7_in.th  = side6_ff.th;
      side7_in.td  = side6_ff.td;
      side7_in.neg = num7_in[45];
      side7_in.ub  = uu6_ff[46:2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff <= 1'b0;
      end else begin
         v7_ff <= v6_ff;
      end
      num7_ff  <= num7_in;
      den7_ff  <= DVS_W'(den7_in);
      side7_ff <= side7_in;
   end

   // Restoring divider for the acceleration.
   logic        dva_val [0:DIV_STAGES];
   div_type     dva [0:DIV_STAGES];
   dside_type   dside_ff [1:DIV_STAGES];
   logic [45:0] num_mag;

   assign num_mag     = side7_ff.neg ? 46'(-num7_ff) : 46'(num7_ff);
   assign dva_val[0]  = v7_ff;
   assign dva[0].rem  = REM_W'({num_mag, 16'd0});
   assign dva[0].dvs  = den7_ff;
   assign dva[0].quo  = '0;

   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
      pds_div_stage u_acc_stage (
         .clock     (clock),
         .reset     (reset),
         .bit_idx   (6'(DIV_STAGES - 1 - g)),
         .src_valid (dva_val[g]),
         .src_div   (dva[g]),
         .valid_ff  (dva_val[g+1]),
         .div_ff    (dva[g+1])
      );
   end

   always_ff @(posedge clock) begin
      dside_ff[1] <= side7_ff;
      for (int i = 1; i < DIV_STAGES; i++) begin
         dside_ff[i+1] <= dside_ff[i];
      end
   end

   // Acceleration over ten. The force squared over four is multiplied by a
   // reciprocal of 625 in four partial products.
   logic             v8_ff;
   logic [63:0]      p10a8_ff, p10a8_in;
   logic [22:0]      ub_lo8, rc_lo8, rc_hi8;
   logic [21:0]      ub_hi8;
   logic [45:0]      pll8_ff, pll8_in, plh8_ff, plh8_in;
   logic [44:0]      phl8_ff, phl8_in, phh8_ff, phh8_in;
   dside_type        side8_ff;

   assign p10a8_in = dva[DIV_STAGES].quo[31:0] * RECIP10;
   assign ub_lo8   = dside_ff[DIV_STAGES].ub[22:0];
   assign ub_hi8   = dside_ff[DIV_STAGES].ub[44:23];
   assign rc_lo8   = RECIP625[22:0];
   assign rc_hi8   = RECIP625[45:23];
   assign pll8_in  = ub_lo8 * rc_lo8;
   assign plh8_in  = ub_lo8 * rc_hi8;
   assign phl8_in  = ub_hi8 * rc_lo8;
   assign phh8_in  = ub_hi8 * rc_hi8;

   always_ff @(posedge clock) begin
      if (reset) begin
         v8_ff <= 1'b0;
      end else begin
         v8_ff <= dva_val[DIV_STAGES];
      end
      p10a8_ff <= p10a8_in;
      pll8_ff  <= pll8_in;
      plh8_ff  <= plh8_in;
      phl8_ff  <= phl8_in;
      phh8_ff  <= phh8_in;
      side8_ff <= dside_ff[DIV_STAGES];
   end

   // New rate.
   logic               v9_ff;
   logic signed [25:0] acc10_s;
   logic signed [23:0] nr9_ff, nr9_in;
   logic signed [23:0] th9_ff;
   logic [46:0]        mid9;
   logic [91:0]        prod9;
   logic [QUO_W-1:0]   uq9_ff;

   assign acc10_s = side8_ff.neg ? -26'(p10a8_ff[63:35]) : 26'(p10a8_ff[63:35]);
   assign nr9_in  = sat24(27'(side8_ff.td) + 27'(acc10_s));
   assign mid9    = 47'(plh8_ff) + 47'(phl8_ff);
   assign prod9   = {1'b0, phh8_ff, 46'd0} + {22'd0, mid9, 23'd0} + 92'(pll8_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v9_ff <= 1'b0;
      end else begin
         v9_ff <= v8_ff;
      end
      nr9_ff <= nr9_in;
      th9_ff <= side8_ff.th;
      uq9_ff <= prod9[90:55];
   end

   // Rate over ten, rate squared.
   logic               v10_ff;
   logic [23:0]        nr_mag;
   logic [55:0]        p10b10_ff, p10b10_in;
   logic signed [47:0] nrsq10_ff, nrsq10_in;
   logic signed [23:0] nr10_ff, th10_ff;
   logic [QUO_W-1:0]   uq10_ff;

   assign nr_mag    = nr9_ff[23] ? 24'(-nr9_ff) : 24'(nr9_ff);
   assign p10b10_in = nr_mag * RECIP10;
   assign nrsq10_in = nr9_ff * nr9_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v10_ff <= 1'b0;
      end else begin
         v10_ff <= v9_ff;
      end
      p10b10_ff <= p10b10_in;
      nrsq10_ff <= nrsq10_in;
      nr10_ff   <= nr9_ff;
      th10_ff   <= th9_ff;
      uq10_ff   <= uq9_ff;
   end

   // New angle.
   logic               v11_ff;
   logic signed [21:0] nr10_s;
   logic signed [23:0] na11_ff, na11_in, nr11_ff;
   logic signed [47:0] nrsq11_ff;
   logic [QUO_W-1:0]   uq11_ff;

   assign nr10_s  = nr10_ff[23] ? -22'(p10b10_ff[55:35]) : 22'(p10b10_ff[55:35]);
   assign na11_in = sat24(27'(th10_ff) + 27'(nr10_s));

   always_ff @(posedge clock) begin
      if (reset) begin
         v11_ff <= 1'b0;
      end else begin
         v11_ff <= v10_ff;
      end
      na11_ff   <= na11_in;
      nr11_ff   <= nr10_ff;
      nrsq11_ff <= nrsq10_ff;
      uq11_ff   <= uq10_ff;
   end

   // Angle scaled by two over pi, termination test.
   logic               v12_ff;
   logic signed [55:0] xp12_ff, xp12_in;
   logic               term12_ff, term12_in;
   logic signed [23:0] na12_ff, nr12_ff;
   logic signed [47:0] nrsq12_ff;
   logic [QUO_W-1:0]   uq12_ff;

   assign xp12_in   = na11_ff * TWO_OVER_PI_Q30;
   assign term12_in = !(na11_ff < HALF_PI_Q16 && na11_ff > -HALF_PI_Q16);

   always_ff @(posedge clock) begin
      if (reset) begin
         v12_ff <= 1'b0;
      end else begin
         v12_ff <= v11_ff;
      end
      xp12_ff   <= xp12_in;
      term12_ff <= term12_in;
      na12_ff   <= na11_ff;
      nr12_ff   <= nr11_ff;
      nrsq12_ff <= nrsq11_ff;
      uq12_ff   <= uq11_ff;
   end

   // Angle term squared.
   logic               v13_ff;
   logic signed [25:0] x13;
   logic signed [51:0] xx13_ff, xx13_in;
   logic               term13_ff;
   logic signed [23:0] na13_ff, nr13_ff;
   logic signed [47:0] nrsq13_ff;
   logic [QUO_W-1:0]   uq13_ff;

   assign x13     = xp12_ff[55:30];
   assign xx13_in = x13 * x13;

   always_ff @(posedge clock) begin
      if (reset) begin
         v13_ff <= 1'b0;
      end else begin
         v13_ff <= v12_ff;
      end
      xx13_ff   <= xx13_in;
      term13_ff <= term12_ff;
      na13_ff   <= na12_ff;
      nr13_ff   <= nr12_ff;
      nrsq13_ff <= nrsq12_ff;
      uq13_ff   <= uq12_ff;
   end

   // Penalty sum over 65536000.
   logic               v14_ff;
   logic [52:0]        sum14;
   logic [60:0]        pen14_ff, pen14_in;
   logic               term14_ff;
   logic signed [23:0] na14_ff, nr14_ff;

   assign sum14    = 53'(xx13_ff) + 53'(nrsq13_ff) + 53'(uq13_ff);
   assign pen14_in = sum14[47:16] * RECIP1000;

   always_ff @(posedge clock) begin
      if (reset) begin
         v14_ff <= 1'b0;
      end else begin
         v14_ff <= v13_ff;
      end
      pen14_ff  <= pen14_in;
      term14_ff <= term13_ff;
      na14_ff   <= na13_ff;
      nr14_ff   <= nr13_ff;
   end

   // Reward and result register.
   logic               out_strobe_ff;
   logic signed [23:0] out_angle_ff, out_rate_ff;
   logic [16:0]        out_reward_ff, out_reward_in;
   logic               out_terminal_ff;
   logic [22:0]        pen15;

   assign pen15 = pen14_ff[60:38];

   always_comb begin
      if (term14_ff || pen15 >= 23'(ONE_Q16)) begin
         out_reward_in = '0;
      end else begin
         out_reward_in = ONE_Q16 - 17'(pen15);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_strobe_ff <= 1'b0;
      end else begin
         out_strobe_ff <= v14_ff;
      end
      out_angle_ff    <= na14_ff;
      out_rate_ff     <= nr14_ff;
      out_reward_ff   <= out_reward_in;
      out_terminal_ff <= term14_ff;
   end

   assign rsp_strobe     = out_strobe_ff;
   assign rsp_next_angle = out_angle_ff;
   assign rsp_next_rate  = out_rate_ff;
   assign rsp_reward     = out_reward_ff;
   assign rsp_terminal   = out_terminal_ff;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##PIPE_LATENCY rsp_strobe)
      else $error("Result strobe missing after start.");

   a_terminal_reward: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_terminal |-> rsp_reward == 17'd0)
      else $error("Terminal step with nonzero reward.");

   a_reward_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_reward <= ONE_Q16)
      else $error("Reward above one.");

endmodule

// ----- test/pendulum_dynamics_step_core_tb.sv -----
`timescale 1ns / 1ps

module pendulum_dynamics_step_core_tb;

   localparam int        RANDOM_WORDS  = 1880;
   localparam int        STALL_LIMIT   = 4000;
   localparam int        DRAIN_CYCLES  = 90;
   localparam longint    INV_TWO_PI    = 683565276;
   localparam longint    TWO_PI_SCALED = 1686629713;
   localparam longint    CORDIC_START  = 652032874;
   localparam longint    TWO_OVER_PI   = 683565276;
   localparam longint    HALF_PI       = 102944;
   localparam longint    STATE_MAX     = 8388607;
   localparam longint    STATE_MIN     = -8388608;
   localparam longint    REWARD_ONE    = 65536;

   typedef struct {
      logic signed [23:0] next_angle;
      logic signed [23:0] next_rate;
      logic [16:0]        reward;
      logic               terminal;
   } step_result_type;

   typedef struct {
      logic signed [23:0] angle;
      logic signed [23:0] rate;
      logic signed [22:0] action;
      logic signed [20:0] noise;
      logic               pinned;
      logic [16:0]        reward;
      logic               terminal;
   } step_row_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic signed [23:0] req_angle;
   logic signed [23:0] req_rate;
   logic signed [22:0] req_action;
   logic signed [20:0] req_noise_sample;
   logic               rsp_strobe;
   logic signed [23:0] rsp_next_angle;
   logic signed [23:0] rsp_next_rate;
   logic [16:0]        rsp_reward;
   logic               rsp_terminal;

   logic               req_pinned;
   logic [16:0]        req_pin_reward;
   logic               req_pin_terminal;

   step_result_type    pending_steps[$];
   int                 error_count;
   int                 idle_cycles;

   pendulum_dynamics_step_core u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_angle        (req_angle),
      .req_rate         (req_rate),
      .req_action       (req_action),
      .req_noise_sample (req_noise_sample),
      .rsp_strobe       (rsp_strobe),
      .rsp_next_angle   (rsp_next_angle),
      .rsp_next_rate    (rsp_next_rate),
      .rsp_reward       (rsp_reward),
      .rsp_terminal     (rsp_terminal)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   function automatic longint clamp_state(longint v);
      if (v > STATE_MAX) return STATE_MAX;
      if (v < STATE_MIN) return STATE_MIN;
      return v;
   endfunction

   function automatic step_result_type pendulum_step(logic signed [23:0] angle,
                                                     logic signed [23:0] rate,
                                                     logic signed [22:0] action,
                                                     logic signed [20:0] noise);
      step_result_type res;
      longint       th, td, u, r, z, x, y, nx, sn, cs, sc, cc, t2;
      longint       num, den, acc, nr, na, xs;
      logic [63:0]  prod, total, pen;
      logic [31:0]  phase, shifted, d;
      logic [1:0]   q;
      th = angle;
      td = rate;
      u = longint'(action) + longint'(noise);
      prod = th * INV_TWO_PI;
      phase = prod[47:16];
      shifted = phase + 32'h2000_0000;
      q = shifted[31:30];
      d = phase - {q, 30'b0};
      r = longint'($signed(d));
      z = (r * TWO_PI_SCALED) >>> 30;
      x = CORDIC_START;
      y = 0;
      for (int i = 0; i < pds_pkg::CORDIC_ITERATIONS && i < 31; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z = z - longint'(pds_pkg::ATAN_Q30[i]);
         end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z = z + longint'(pds_pkg::ATAN_Q30[i]);
         end
         x = nx;
      end
      case (q)
         2'd0: begin cs = x;  sn = y;  end
         2'd1: begin cs = -y; sn = x;  end
         2'd2: begin cs = -x; sn = -y; end
         default: begin cs = y; sn = -x; end
      endcase
      sc = (sn * cs) >>> 30;
      cc = (cs * cs) >>> 30;
      t2 = (td * td) >>> 16;
      num = 294 * (sn >>> 6) - 3 * ((t2 * sc) >>> 22) - 3 * ((cs * u) >>> 22);
      den = (longint'(20) << 24) - 3 * (cc >>> 6);
      acc = (num * 65536) / den;
      nr = clamp_state(td + acc / 10);
      na = clamp_state(th + nr / 10);
      res.next_angle = na[23:0];
      res.next_rate = nr[23:0];
      if (na < HALF_PI && na > -HALF_PI) begin
         xs = (na * TWO_OVER_PI) >>> 30;
         total = xs * xs + nr * nr + (u * u) / 2500;
         pen = total / 64'd65536000;
         res.reward = (pen >= REWARD_ONE) ? 17'd0 : 17'(REWARD_ONE - pen);
         res.terminal = 1'b0;
      end else begin
         res.reward = 17'd0;
         res.terminal = 1'b1;
      end
      return res;
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      $display("mismatch on %s: got %0d, expected %0d at %0t", field, got, want, $time);
      error_count++;
   endtask

   always @(posedge clock) begin
      step_result_type want;
      if (!reset) begin
         if (start && !busy) begin
            want = pendulum_step(req_angle, req_rate, req_action, req_noise_sample);
            if (req_pinned) begin
               want.reward = req_pin_reward;
               want.terminal = req_pin_terminal;
            end
            pending_steps.push_back(want);
         end
         if (rsp_strobe) begin
            if (pending_steps.size() == 0) begin
               report_mismatch("unexpected word", 1, 0);
            end else begin
               want = pending_steps.pop_front();
               if (rsp_next_angle !== want.next_angle)
                  report_mismatch("next_angle", rsp_next_angle, want.next_angle);
               if (rsp_next_rate !== want.next_rate)
                  report_mismatch("next_rate", rsp_next_rate, want.next_rate);
               if (rsp_reward !== want.reward)
                  report_mismatch("reward", rsp_reward, want.reward);
               if (rsp_terminal !== want.terminal)
                  report_mismatch("terminal", rsp_terminal, want.terminal);
            end
         end
         if ((start && !busy) || rsp_strobe) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   always @(posedge clock) begin
      if (idle_cycles >= STALL_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic send_word(step_row_type row);
      start <= 1'b1;
      req_angle <= row.angle;
      req_rate <= row.rate;
      req_action <= row.action;
      req_noise_sample <= row.noise;
      req_pinned <= row.pinned;
      req_pin_reward <= row.reward;
      req_pin_terminal <= row.terminal;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic idle_gap(int word_index);
      int gap;
      int pick;
      pick = $urandom_range(99);
      if ((word_index / 150) % 3 == 1) gap = 0;
      else if (pick < 50) gap = 0;
      else if (pick < 90) gap = $urandom_range(3, 1);
      else gap = $urandom_range(60, 10);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic step_row_type random_row();
      step_row_type row;
      row.pinned = 1'b0;
      row.reward = '0;
      row.terminal = 1'b0;
      if ($urandom_range(99) < 70) begin
         row.angle = 24'($signed($urandom_range(196608)) - 98304);
         row.rate = 24'($signed($urandom_range(393216)) - 196608);
         row.action = 23'($signed($urandom_range(6553600)) - 3276800);
         row.noise = 21'($signed($urandom_range(1310720)) - 655360);
      end else begin
         row.angle = 24'($urandom);
         row.rate = 24'($urandom);
         row.action = 23'($urandom);
         row.noise = 21'($urandom);
      end
      return row;
   endfunction

   step_row_type directed_rows [0:15] = '{
      '{24'sd0, 24'sd0, 23'sd0, 21'sd0, 1'b1, 17'd65536, 1'b0},
      '{24'sd6553600, 24'sd0, 23'sd0, 21'sd0, 1'b1, 17'd0, 1'b1},
      '{-24'sd6553600, 24'sd0, 23'sd0, 21'sd0, 1'b1, 17'd0, 1'b1},
      '{-24'sd823550, 24'sd8235500, 23'sd0, 21'sd0, 1'b1, 17'd0, 1'b0},
      '{24'sd8388607, 24'sd8388607, 23'sd4194303, 21'sd1048575, 1'b0, 17'd0, 1'b0},
      '{-24'sd8388608, -24'sd8388608, -23'sd4194304, -21'sd1048576, 1'b0, 17'd0, 1'b0},
      '{24'sd8388607, -24'sd8388608, 23'sd0, 21'sd0, 1'b0, 17'd0, 1'b0},
      '{-24'sd8388608, 24'sd8388607, 23'sd0, 21'sd0, 1'b0, 17'd0, 1'b0},
      '{24'sd0, 24'sd0, 23'sd3276800, 21'sd655360, 1'b0, 17'd0, 1'b0},
      '{24'sd0, 24'sd0, -23'sd3276800, -21'sd655360, 1'b0, 17'd0, 1'b0},
      '{24'sd102943, 24'sd0, 23'sd0, 21'sd0, 1'b0, 17'd0, 1'b0},
      '{-24'sd102943, 24'sd0, 23'sd0, 21'sd0, 1'b0, 17'd0, 1'b0},
      '{24'sd51472, 24'sd65536, 23'sd655360, -21'sd65536, 1'b0, 17'd0, 1'b0},
      '{24'sd0, 24'sd8388607, 23'sd0, 21'sd0, 1'b0, 17'd0, 1'b0},
      '{24'sd205887, 24'sd0, 23'sd0, 21'sd0, 1'b0, 17'd0, 1'b0},
      '{24'sd411775, -24'sd1310720, 23'sd1000000, 21'sd300000, 1'b0, 17'd0, 1'b0}
   };

   initial begin
      int wait_cycles;
      error_count = 0;
      idle_cycles = 0;
      reset <= 1'b1;
      start <= 1'b0;
      req_angle <= '0;
      req_rate <= '0;
      req_action <= '0;
      req_noise_sample <= '0;
      req_pinned <= 1'b0;
      req_pin_reward <= '0;
      req_pin_terminal <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_rows[i]) begin
         send_word(directed_rows[i]);
         idle_gap(i);
      end
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n == RANDOM_WORDS / 2) begin
            start <= 1'b0;
            while (pending_steps.size() != 0) @(posedge clock);
         end
         send_word(random_row());
         idle_gap(n);
      end
      start <= 1'b0;
      wait_cycles = 0;
      while (pending_steps.size() != 0 && wait_cycles < STALL_LIMIT) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_steps.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
